// ===== src/assert_macros.svh =====
// Assertion macros shared by the slot event generator modules.
// Every user must have i_clk and i_rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MTSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot event generator: assertion failed");

// Next-cycle implication, checked outside reset.
`define MTSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot event generator: assertion failed");

`endif

// ===== src/mtse_pkg.sv =====
// Package for the multitouch slot event generator: sizes, codes and shared types.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package mtse_pkg;

    localparam int SLOT_COUNT  = 10;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
    localparam int RECIP_SHIFT = 32;
    // Rounded-up reciprocal of the slot count; exact quotient for 16-bit inputs.
    localparam logic [32:0] SLOT_RECIP =
        33'(((64'd1 << RECIP_SHIFT) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [16:0] VALUE_RELEASE = '1;

    typedef enum logic [1:0] {
        CMD_DOWN        = 2'd0,
        CMD_MOVE        = 2'd1,
        CMD_UP          = 2'd2,
        CMD_RELEASE_ALL = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_SLOT    = 3'd0,
        KIND_TRACK   = 3'd1,
        KIND_X       = 3'd2,
        KIND_Y       = 3'd3,
        KIND_SIZE    = 3'd4,
        KIND_PRESS   = 3'd5,
        KIND_CONTACT = 3'd6,
        KIND_SYNC    = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        CFG_DEAD_BAND  = 3'd0,
        CFG_TOUCH_SIZE = 3'd1,
        CFG_PRESSURE   = 3'd2,
        CFG_ID_START   = 3'd3,
        CFG_ID_LIMIT   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] dead_band;
        logic [7:0]  touch_size;
        logic [7:0]  pressure;
        logic [15:0] id_start;
        logic [15:0] id_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        dead_band:  16'd1,
        touch_size: 8'd6,
        pressure:   8'd60,
        id_start:   16'd100,
        id_limit:   16'd65000
    };

    typedef struct packed {
        t_cmd              cmd;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       x;
        logic [15:0]       y;
    } t_item;

    typedef struct packed {
        logic        strobe;
        t_kind       kind;
        logic [16:0] value;
        logic        last;
    } t_event;

endpackage

// ===== src/mtse_front.sv =====
// Front end: takes a command, reduces the slot number modulo the slot count
// by a reciprocal multiply, and pushes the decoded item into the queue. Uses mtse_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  logic [1:0]     i_cmd,
    input  logic [15:0]    i_slot_number,
    input  logic [15:0]    i_pos_x,
    input  logic [15:0]    i_pos_y,
    output logic           o_push,
    output mtse_pkg::t_item o_item,
    input  logic           i_full
);
    import mtse_pkg::*;

    logic        r_valid;
    t_cmd        r_cmd;
    logic [15:0] r_raw;
    logic [15:0] r_quot;
    logic [15:0] r_x;
    logic [15:0] r_y;

    logic [48:0] quot_prod;
    logic [15:0] quot_back;
    logic [15:0] rem;
    logic        accept;

    assign quot_prod = 49'(i_slot_number) * 49'(SLOT_RECIP);
    assign quot_back = 16'(r_quot * 16'(SLOT_COUNT));
    assign rem       = r_raw - quot_back;

    assign o_busy = r_valid && i_full;
    assign accept = i_start && !o_busy;
    assign o_push = r_valid && !i_full;

    assign o_item.cmd  = r_cmd;
    assign o_item.slot = rem[SLOT_W-1:0];
    assign o_item.x    = r_x;
    assign o_item.y    = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_raw  <= i_slot_number;
            r_quot <= quot_prod[RECIP_SHIFT+15:RECIP_SHIFT];
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
        end
    end

    `MTSE_ASSERT_IMP(a_front_push_room, o_push, !i_full)

endmodule

// ===== src/mtse_queue.sv =====
// Short command queue between the front end and the event sequencer.
// Uses mtse_pkg for the item type and depth.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtse_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mtse_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output mtse_pkg::t_item o_item,
    output logic            o_empty
);
    import mtse_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `MTSE_ASSERT_IMP(a_queue_bound, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH))

endmodule

// ===== src/mtse_back.sv =====
// Event sequencer: pops commands, keeps per-slot state and the tracking-id
// counter, and emits one protocol-B event per cycle while commands are queued. Uses mtse_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtse_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mtse_pkg::t_cfg   i_cfg,
    input  mtse_pkg::t_item  i_item,
    input  logic             i_empty,
    output logic             o_pop,
    output mtse_pkg::t_event o_event
);
    import mtse_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DN_TRACK,
        ST_DN_X,
        ST_DN_Y,
        ST_DN_SIZE,
        ST_DN_PRESS,
        ST_MV_X,
        ST_MV_Y,
        ST_UP_TRACK,
        ST_RA_TRACK,
        ST_RA_SLOT,
        ST_CONTACT,
        ST_SYNC
    } t_state;

    t_state              r_state,   n_state;
    logic [SLOT_COUNT-1:0] r_active, n_active;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [15:0]         r_next_id, n_next_id;
    logic [SLOT_W-1:0]   r_slot,    n_slot;
    logic [SLOT_W-1:0]   r_idx,     n_idx;
    logic [15:0]         r_x,       n_x;
    logic [15:0]         r_y,       n_y;
    logic                r_contact, n_contact;
    logic                r_evt_strobe, n_evt_strobe;
    t_kind               r_evt_kind,   n_evt_kind;
    logic [16:0]         r_evt_value,  n_evt_value;
    logic                r_evt_last,   n_evt_last;

    logic [15:0] r_last_x [SLOT_COUNT];
    logic [15:0] r_last_y [SLOT_COUNT];

    logic        pos_write;
    logic [15:0] old_x;
    logic [15:0] old_y;
    logic [15:0] diff_x;
    logic [15:0] diff_y;
    logic        moved;
    logic [16:0] id_inc;
    logic [CNT_W-1:0] count_dn;
    logic [CNT_W-1:0] count_up;
    logic        ra_walk;

    // Move check on the head item, done in the cycle it is popped.
    assign old_x  = r_last_x[i_item.slot];
    assign old_y  = r_last_y[i_item.slot];
    assign diff_x = (i_item.x > old_x) ? i_item.x - old_x : old_x - i_item.x;
    assign diff_y = (i_item.y > old_y) ? i_item.y - old_y : old_y - i_item.y;
    assign moved  = r_active[i_item.slot] &&
                    ((diff_x > i_cfg.dead_band) || (diff_y > i_cfg.dead_band));

    assign id_inc   = {1'b0, r_next_id} + 17'd1;
    assign count_dn = r_active[r_slot] ? r_count : r_count + 1'b1;
    assign count_up = (r_count != '0) ? r_count - 1'b1 : r_count;

    // The release-all walk clears the active bits one by one and zeroes the count at
    // its end, so the two only agree outside the walk.
    assign ra_walk = (r_state == ST_RA_TRACK) || (r_state == ST_RA_SLOT);

    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_count      = r_count;
        n_next_id    = r_next_id;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_x          = r_x;
        n_y          = r_y;
        n_contact    = r_contact;
        n_evt_strobe = 1'b0;
        n_evt_kind   = r_evt_kind;
        n_evt_value  = r_evt_value;
        n_evt_last   = 1'b0;
        o_pop        = 1'b0;
        pos_write    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop        = 1'b1;
                    n_slot       = i_item.slot;
                    n_x          = i_item.x;
                    n_y          = i_item.y;
                    n_evt_strobe = 1'b1;
                    n_evt_kind   = KIND_SLOT;
                    n_evt_value  = 17'(i_item.slot);
                    case (i_item.cmd)
                        CMD_DOWN: begin
                            n_state = ST_DN_TRACK;
                        end
                        CMD_MOVE: begin
                            n_evt_last = !moved;
                            n_state    = moved ? ST_MV_X : ST_IDLE;
                        end
                        CMD_UP: begin
                            n_contact = 1'b0;
                            if (r_active[i_item.slot]) begin
                                n_state = ST_UP_TRACK;
                            end else if (r_count == '0) begin
                                n_state = ST_CONTACT;
                            end else begin
                                n_state = ST_SYNC;
                            end
                        end
                        default: begin
                            // Release all walks every slot from zero.
                            n_evt_value = '0;
                            n_idx       = '0;
                            n_state     = ST_RA_TRACK;
                        end
                    endcase
                end
            end
            ST_DN_TRACK: begin
                n_evt_strobe = 1'b1;
                n_evt_kind   = KIND_TRACK;
                n_evt_value  = {1'b0, r_next_id};
                n_next_id    = (id_inc > {1'b0, i_cfg.id_limit}) ? i_cfg.id_start
                                                                 : id_inc[15:0];
                n_state      = ST_DN_X;
            end
            ST_DN_X: begin
                n_evt_strobe = 1'b1;
                n_evt_kind   = KIND_X;
                n_evt_value  = {1'b0, r_x};
                n_state      = ST_DN_Y;
            end
            ST_DN_Y: begin
                n_evt_strobe = 1'b1;
                n_evt_kind   = KIND_Y;
                n_evt_value  = {1'b0, r_y};
                n_state      = ST_DN_SIZE;
            end
            ST_DN_SIZE: begin
                n_evt_strobe = 1'b1;
                n_evt_kind   = KIND_SIZE;
                n_evt_value  = 17'(i_cfg.touch_size);
                n_state      = ST_DN_PRESS;
            end
            ST_DN_PRESS: begin
                n_evt_strobe     = 1'b1;
                n_evt_kind       = KIND_PRESS;
                n_evt_value      = 17'(i_cfg.pressure);
                pos_write        = 1'b1;
                n_active[r_slot] = 1'b1;
                n_count          = count_dn;
                n_contact        = 1'b1;
                n_state          = (count_dn == CNT_W'(1)) ? ST_CONTACT : ST_SYNC;
            end
            ST_MV_X: begin
                n_evt_strobe = 1'b1;
                n_evt_kind   = KIND_X;
                n_evt_value  = {1'b0, r_x};
                n_state      = ST_MV_Y;
            end
            ST_MV_Y: begin
                n_evt_strobe = 1'b1;
                n_evt_kind   = KIND_Y;
                n_evt_value  = {1'b0, r_y};
                pos_write    = 1'b1;
                n_state      = ST_SYNC;
            end
            ST_UP_TRACK: begin
                n_evt_strobe     = 1'b1;
                n_evt_kind       = KIND_TRACK;
                n_evt_value      = VALUE_RELEASE;
                n_active[r_slot] = 1'b0;
                n_count          = count_up;
                n_state          = (count_up == '0) ? ST_CONTACT : ST_SYNC;
            end
            ST_RA_TRACK: begin
                n_evt_strobe    = 1'b1;
                n_evt_kind      = KIND_TRACK;
                n_evt_value     = VALUE_RELEASE;
                n_active[r_idx] = 1'b0;
                if (r_idx == SLOT_W'(SLOT_COUNT - 1)) begin
                    n_count   = '0;
                    n_contact = 1'b0;
                    n_state   = ST_CONTACT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_RA_SLOT;
                end
            end
            ST_RA_SLOT: begin
                n_evt_strobe = 1'b1;
                n_evt_kind   = KIND_SLOT;
                n_evt_value  = 17'(r_idx);
                n_state      = ST_RA_TRACK;
            end
            ST_CONTACT: begin
                n_evt_strobe = 1'b1;
                n_evt_kind   = KIND_CONTACT;
                n_evt_value  = 17'(r_contact);
                n_state      = ST_SYNC;
            end
            ST_SYNC: begin
                n_evt_strobe = 1'b1;
                n_evt_kind   = KIND_SYNC;
                n_evt_value  = '0;
                n_evt_last   = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_active     <= '0;
            r_count      <= '0;
            r_next_id    <= CFG_RESET.id_start;
            r_evt_strobe <= 1'b0;
            r_evt_last   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_count      <= n_count;
            r_next_id    <= n_next_id;
            r_evt_strobe <= n_evt_strobe;
            r_evt_last   <= n_evt_last;
        end
        r_slot      <= n_slot;
        r_idx       <= n_idx;
        r_x         <= n_x;
        r_y         <= n_y;
        r_contact   <= n_contact;
        r_evt_kind  <= n_evt_kind;
        r_evt_value <= n_evt_value;
    end

    // Last reported positions; only read for slots that a down has made active.
    always_ff @(posedge i_clk) begin
        if (pos_write) begin
            r_last_x[r_slot] <= r_x;
            r_last_y[r_slot] <= r_y;
        end
    end

    assign o_event.strobe = r_evt_strobe;
    assign o_event.kind   = r_evt_kind;
    assign o_event.value  = r_evt_value;
    assign o_event.last   = r_evt_last;

    `MTSE_ASSERT_IMP(a_count_matches_bits, !ra_walk, $countones(r_active) == int'(r_count))
    `MTSE_ASSERT_NXT(a_sync_ends_run, r_state == ST_SYNC, r_evt_strobe && r_evt_last && (r_state == ST_IDLE))

endmodule

// ===== src/multitouch_slot_event_generator.sv =====
// Top level of the multitouch slot event generator: configuration registers
// and the front end, queue and sequencer. Uses mtse_pkg, mtse_front, mtse_queue, mtse_back.
`timescale 1ns / 1ps

//  Channel   | Direction | Handshake                       | Payload
//  ----------+-----------+---------------------------------+------------------------------------
//  command   | in        | start high, busy low            | i_cmd, i_slot_number, i_pos_x/y
//  events    | out       | o_event_strobe, one cycle each  | o_event_kind/value, o_last_event
//  config    | in        | i_cfg_valid and o_cfg_ready     | i_cfg_index, i_cfg_data
//
// The slot reduction multiply runs in the accepting cycle and the front stage registers the
// quotient; the front stage then forms the remainder and pushes the command into the queue,
// and the sequencer pops it from there and registers the first event onto the ports.
// Events follow at one per cycle with no gap between commands while the queue holds the next
// one; a down gives 7 events, 8 when it raises contact, a move 1 or 4, an up 2 to 4, and
// release all 2*SLOT_COUNT+2 (22 by default).
// Reset is synchronous and active low; it clears all slots and restores the registers.
// The event receiver cannot stall; busy rises only when the front stage and the queue
// are both full while the sequencer works through a long run.

module multitouch_slot_event_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command transfer.
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_slot_number,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    // Event transfer.
    output logic        o_event_strobe,
    output logic [2:0]  o_event_kind,
    output logic signed [16:0] o_event_value,
    output logic        o_last_event,
    // Configuration write transfer.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mtse_pkg::*;

    t_cfg   r_cfg;
    logic   push;
    t_item  push_item;
    logic   q_full;
    logic   pop;
    t_item  head_item;
    logic   q_empty;
    t_event evt;

    // Configuration writes are always taken. The user must send them only while the block is idle,
    // so that the sequencer sees new values only on the next command; the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEAD_BAND:  r_cfg.dead_band  <= i_cfg_data;
                CFG_TOUCH_SIZE: r_cfg.touch_size <= i_cfg_data[7:0];
                CFG_PRESSURE:   r_cfg.pressure   <= i_cfg_data[7:0];
                CFG_ID_START:   r_cfg.id_start   <= i_cfg_data;
                CFG_ID_LIMIT:   r_cfg.id_limit   <= i_cfg_data;
                default: begin
                    // Indexes past the register list are dropped.
                end
            endcase
        end
    end

    // The front end decodes the command and folds the slot number into range.
    mtse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_cmd         (i_cmd),
        .i_slot_number (i_slot_number),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .o_push        (push),
        .o_item        (push_item),
        .i_full        (q_full)
    );

    // The queue lets the host keep sending while a long run of events plays out.
    mtse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (q_empty)
    );

    // The sequencer owns all slot state and drives the registered event outputs.
    mtse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (head_item),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_event (evt)
    );

    assign o_event_strobe = evt.strobe;
    assign o_event_kind   = evt.kind;
    assign o_event_value  = evt.value;
    assign o_last_event   = evt.last;

endmodule
